[src/satt_pkg.sv]
// ----------------------------------------------------------------------------
// satt_pkg: shared definitions for the six-axis top-five tracker
// Holds the axis count, parameter defaults and the control struct that the
// top level hands to the lanes and to the result merge stage.
// ----------------------------------------------------------------------------
package satt_pkg;

	localparam int AXES             = 6;
	localparam int DEF_TOP_COUNT    = 5;
	localparam int DEF_SAMPLE_WIDTH = 16;

	// Control for one cycle: a sample request is taken, and whether it closes
	// the window.
	typedef struct packed {
		logic accept;
		logic window_end;
	} satt_ctl_t;

endpackage

[src/satt_lane.sv]
// ----------------------------------------------------------------------------
// satt_lane: ranked store for one axis
// A row of compare-and-shift cells that keeps the largest values seen in the
// window, in descending order, with a valid bit per cell.
// ----------------------------------------------------------------------------
module satt_lane
	import satt_pkg::*;
#(
	parameter int TOP_COUNT    = DEF_TOP_COUNT,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  satt_ctl_t                      ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic signed [SAMPLE_WIDTH-1:0] nxt_val [TOP_COUNT],
	output logic                           nxt_vld [TOP_COUNT]
);

	logic signed [SAMPLE_WIDTH-1:0] val_q [TOP_COUNT];
	logic                           vld_q [TOP_COUNT];
	logic                           gt    [TOP_COUNT];

	// Since the store is sorted and empty cells sit at the bottom, the "new
	// value goes here or above" flag is monotone down the row. The insertion
	// point is the first cell whose flag is set.
	always_comb begin
		for (int j = 0; j < TOP_COUNT; j++) begin
			gt[j] = !vld_q[j] || (sample > val_q[j]);
		end
		nxt_val[0] = gt[0] ? sample : val_q[0];
		nxt_vld[0] = gt[0] ? 1'b1 : vld_q[0];
		for (int j = 1; j < TOP_COUNT; j++) begin
			if (!gt[j]) begin
				nxt_val[j] = val_q[j];
				nxt_vld[j] = vld_q[j];
			end else if (gt[j-1]) begin
				nxt_val[j] = val_q[j-1];
				nxt_vld[j] = vld_q[j-1];
			end else begin
				nxt_val[j] = sample;
				nxt_vld[j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TOP_COUNT; j++) vld_q[j] <= 1'b0;
		end else if (ctl.accept) begin
			for (int j = 0; j < TOP_COUNT; j++) vld_q[j] <= ctl.window_end ? 1'b0 : nxt_vld[j];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			for (int j = 0; j < TOP_COUNT; j++) val_q[j] <= nxt_val[j];
		end
	end

endmodule

[src/satt_merge.sv]
// ----------------------------------------------------------------------------
// satt_merge: result bank and output sequencer
// Gathers the six lanes' ranks into one result per rank at the end of a
// window and shifts them out, rank 0 first.
// ----------------------------------------------------------------------------
module satt_merge
	import satt_pkg::*;
#(
	parameter int TOP_COUNT    = DEF_TOP_COUNT,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int RANK_W       = 3,
	parameter int OUT_W        = 104
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  satt_ctl_t                      ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] lane_val [AXES][TOP_COUNT],
	input  logic                           lane_vld [AXES][TOP_COUNT],
	output logic                           busy,
	output logic                           tvalid,
	input  logic                           tready,
	output logic [OUT_W-1:0]               tdata,
	output logic [0:0]                     tuser,
	output logic                           tlast
);

	logic [SAMPLE_WIDTH-1:0] bank_q [TOP_COUNT][AXES];
	logic                    fill_q [TOP_COUNT];
	logic [RANK_W-1:0]       rank_q;
	logic                    busy_q;
	logic                    last_rank;
	logic                    take;

	assign last_rank = (rank_q == RANK_W'(TOP_COUNT - 1));
	assign take      = busy_q && tready;
	assign busy      = busy_q;
	assign tvalid    = busy_q;
	assign tlast     = last_rank;
	assign tuser     = fill_q[0];

	always_comb begin
		tdata = '0;
		tdata[RANK_W-1:0] = rank_q;
		for (int a = 0; a < AXES; a++) begin
			tdata[RANK_W + a*SAMPLE_WIDTH +: SAMPLE_WIDTH] = bank_q[0][a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rank_q <= '0;
		end else if (ctl.accept && ctl.window_end) begin
			busy_q <= 1'b1;
			rank_q <= '0;
		end else if (take) begin
			busy_q <= !last_rank;
			rank_q <= last_rank ? '0 : rank_q + 1'b1;
		end
	end

	// Empty ranks read as zero. Every lane sees every sample, so lane 0's
	// valid bit stands for the whole rank.
	always_ff @(posedge clk) begin
		if (ctl.accept && ctl.window_end) begin
			for (int r = 0; r < TOP_COUNT; r++) begin
				fill_q[r] <= lane_vld[0][r];
				for (int a = 0; a < AXES; a++) begin
					bank_q[r][a] <= lane_vld[a][r] ? lane_val[a][r] : '0;
				end
			end
		end else if (take) begin
			for (int r = 0; r < TOP_COUNT - 1; r++) begin
				fill_q[r] <= fill_q[r+1];
				for (int a = 0; a < AXES; a++) bank_q[r][a] <= bank_q[r+1][a];
			end
		end
	end

endmodule

[src/six_axis_top5_tracker_top.sv]
// ----------------------------------------------------------------------------
// six_axis_top5_tracker_top: per-axis top-five tracker for IMU samples
// Keeps the largest values of each of six axes over a window and reports
// them in rank order when the window closes.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one six-axis sample per request; tlast marks the
// last sample of a window. Each of the six lanes keeps its axis's largest
// values in a sorted row of compare-and-shift cells, so a sample is absorbed
// in the cycle it is taken; while idle, samples can arrive every cycle.
// When a request with tlast is taken, the updated ranks are copied into the
// result bank in that same edge and the lanes start the next window empty.
// The master channel then presents TOP_COUNT results, rank 0 first, the
// first one in the cycle after the closing sample; tlast flags the last
// rank and tuser tells whether the rank holds a sample.
// Within a window the lanes take a new sample every cycle; a closing sample
// is followed by a transfer of TOP_COUNT results, one per handshake.
// While results are pending the slave side holds tready low, except in the
// cycle the last result is taken. A stalled receiver simply holds the
// current result and, through the bank, stalls the input side.
// Reset clears the lanes' valid bits and the sequencer; no results are pending.
// ----------------------------------------------------------------------------
module six_axis_top5_tracker_top
	import satt_pkg::*;
#(
	parameter int TOP_COUNT    = DEF_TOP_COUNT,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int RANK_W       = (TOP_COUNT > 8) ? 4 : 3,
	parameter int IN_W         = ((AXES * SAMPLE_WIDTH + 7) / 8) * 8,
	parameter int OUT_W        = ((RANK_W + AXES * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// Sample requests.
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, zero fill.
	input  logic [IN_W-1:0]  s_axis_tdata,
	// window_end.
	input  logic             s_axis_tlast,
	// Ranked results.
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// rank, top_accel_x, top_accel_y, top_accel_z, top_rate_x, top_rate_y,
	// top_rate_z, zero fill.
	output logic [OUT_W-1:0] m_axis_tdata,
	// slot_filled.
	output logic [0:0]       m_axis_tuser,
	// final_rank.
	output logic             m_axis_tlast
);

	satt_ctl_t                      ctl;
	logic                           busy;
	logic signed [SAMPLE_WIDTH-1:0] lane_val [AXES][TOP_COUNT];
	logic                           lane_vld [AXES][TOP_COUNT];

	// A new request may enter as soon as the last pending result leaves.
	assign s_axis_tready  = !busy || (m_axis_tready && m_axis_tlast);
	assign ctl.accept     = s_axis_tvalid && s_axis_tready;
	assign ctl.window_end = s_axis_tlast;

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		satt_lane #(
			.TOP_COUNT   (TOP_COUNT),
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sample (s_axis_tdata[a*SAMPLE_WIDTH +: SAMPLE_WIDTH]),
			.nxt_val(lane_val[a]),
			.nxt_vld(lane_vld[a])
		);
	end

	satt_merge #(
		.TOP_COUNT   (TOP_COUNT),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.RANK_W      (RANK_W),
		.OUT_W       (OUT_W)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.lane_val(lane_val),
		.lane_vld(lane_vld),
		.busy    (busy),
		.tvalid  (m_axis_tvalid),
		.tready  (m_axis_tready),
		.tdata   (m_axis_tdata),
		.tuser   (m_axis_tuser),
		.tlast   (m_axis_tlast)
	);

`ifndef SYNTHESIS
	// A sample can only be taken during result transfer when the last result
	// leaves in the same cycle.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.accept && busy) |-> (m_axis_tready && m_axis_tlast))
		else $error("sample taken while results pending");

	// A closing sample starts the result run at rank 0 on the next cycle.
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.accept && s_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tdata[RANK_W-1:0] == '0))
		else $error("result run did not start at rank 0");

	// Once an empty rank is reported, the lower ranks of the run are empty too.
	a_empty_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast && !m_axis_tuser[0]) |=>
		!m_axis_tuser[0])
		else $error("filled rank after an empty one");
`endif

endmodule

[tb/sv/satt_rank_checker.sv]
// ----------------------------------------------------------------------------
// satt_rank_checker: ranked-result checker for the six-axis top-five tracker
// Watches both stream channels, keeps its own sorted per-axis rows of the
// largest values in the open window, and compares every ranked result that
// leaves the block against the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module satt_rank_checker
	import satt_pkg::*;
#(
	parameter int TOP_COUNT    = DEF_TOP_COUNT,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int RANK_W       = (TOP_COUNT > 8) ? 4 : 3,
	parameter int IN_W         = ((AXES * SAMPLE_WIDTH + 7) / 8) * 8,
	parameter int OUT_W        = ((RANK_W + AXES * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,
	input  logic             s_axis_tlast,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OUT_W-1:0] m_axis_tdata,
	input  logic [0:0]       m_axis_tuser,
	input  logic             m_axis_tlast,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic [RANK_W-1:0]                   rank;
		logic                                filled;
		logic [AXES-1:0][SAMPLE_WIDTH-1:0]   val;
		logic                                last;
	} rank_row_t;

	// Ranked results owed by the block, oldest first.
	rank_row_t ranks_due[$];

	// Per-axis sorted rows of the open window, largest first.
	logic signed [SAMPLE_WIDTH-1:0] lane_val [AXES][TOP_COUNT];
	bit                             lane_full [AXES][TOP_COUNT];

	int fail_cnt = 0;

	string axis_name [AXES] = '{"top_accel_x", "top_accel_y", "top_accel_z",
		"top_rate_x", "top_rate_y", "top_rate_z"};

	assign errors = fail_cnt;

	function automatic void clear_lanes();
		for (int a = 0; a < AXES; a++) begin
			for (int j = 0; j < TOP_COUNT; j++) begin
				lane_val[a][j]  = '0;
				lane_full[a][j] = 1'b0;
			end
		end
	endfunction

	// An empty slot counts as below everything; an equal value lands after
	// the stored one.
	function automatic void insert_axis(int ax, logic signed [SAMPLE_WIDTH-1:0] v);
		for (int j = 0; j < TOP_COUNT; j++) begin
			if (!lane_full[ax][j] || v > lane_val[ax][j]) begin
				for (int k = TOP_COUNT - 1; k > j; k--) begin
					lane_val[ax][k]  = lane_val[ax][k-1];
					lane_full[ax][k] = lane_full[ax][k-1];
				end
				lane_val[ax][j]  = v;
				lane_full[ax][j] = 1'b1;
				return;
			end
		end
	endfunction

	function automatic void absorb_sample(logic [IN_W-1:0] d, logic closes);
		rank_row_t row;
		for (int a = 0; a < AXES; a++)
			insert_axis(a, d[a*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
		if (!closes)
			return;
		for (int r = 0; r < TOP_COUNT; r++) begin
			row        = '0;
			row.rank   = RANK_W'(r);
			row.filled = lane_full[0][r];
			for (int a = 0; a < AXES; a++) begin
				if (lane_full[a][r])
					row.val[a] = lane_val[a][r];
			end
			row.last = (r == TOP_COUNT - 1);
			ranks_due.push_back(row);
		end
		clear_lanes();
	endfunction

	function automatic void check_rank(rank_row_t got);
		rank_row_t want;
		if (ranks_due.size() == 0) begin
			$error("ranked result with nothing due: rank %0d", got.rank);
			fail_cnt++;
			return;
		end
		want = ranks_due.pop_front();
		if (got.rank !== want.rank) begin
			$error("rank: expected %0d, actual %0d", want.rank, got.rank);
			fail_cnt++;
		end
		if (got.filled !== want.filled) begin
			$error("slot_filled: expected %0d, actual %0d", want.filled, got.filled);
			fail_cnt++;
		end
		for (int a = 0; a < AXES; a++) begin
			if (got.val[a] !== want.val[a]) begin
				$error("%s: expected %0d, actual %0d", axis_name[a],
					$signed(want.val[a]), $signed(got.val[a]));
				fail_cnt++;
			end
		end
		if (got.last !== want.last) begin
			$error("final_rank: expected %0d, actual %0d", want.last, got.last);
			fail_cnt++;
		end
	endfunction

	function automatic rank_row_t unpack_result();
		rank_row_t row;
		row.rank   = m_axis_tdata[RANK_W-1:0];
		row.filled = m_axis_tuser[0];
		for (int a = 0; a < AXES; a++)
			row.val[a] = m_axis_tdata[RANK_W + a*SAMPLE_WIDTH +: SAMPLE_WIDTH];
		row.last = m_axis_tlast;
		return row;
	endfunction

	initial clear_lanes();

	// Results leave first: a closing sample taken in the same edge only adds
	// rows at the back of the queue.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_rank(unpack_result());
			if (s_axis_tvalid && s_axis_tready)
				absorb_sample(s_axis_tdata, s_axis_tlast);
		end
		pending <= ranks_due.size();
	end

endmodule

[tb/sv/six_axis_top5_tracker_top_tb.sv]
// ----------------------------------------------------------------------------
// six_axis_top5_tracker_top_tb: stream test of the six-axis top-five tracker
// Sends directed windows (single samples, extremes, ties, short and long
// windows) and then random windows of random length, with bursty requests
// and a stalling receiver. A separate checker predicts and compares every
// ranked result; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module six_axis_top5_tracker_top_tb;
	import satt_pkg::*;

	localparam int TOP_COUNT    = DEF_TOP_COUNT;
	localparam int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH;
	localparam int RANK_W       = (TOP_COUNT > 8) ? 4 : 3;
	localparam int IN_W         = ((AXES * SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int OUT_W        = ((RANK_W + AXES * SAMPLE_WIDTH + 7) / 8) * 8;

	// Random stimulus stops once this many samples have gone in.
	localparam int RANDOM_SAMPLES = 450;
	// Cycles with no request taken on either side before the run is called hung.
	localparam int IDLE_LIMIT     = 4000;
	// The first result comes in the cycle after the closing sample; a short
	// tail after draining catches any stray result.
	localparam int TAIL_CYCLES    = 20;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             s_axis_tlast;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [0:0]       m_axis_tuser;
	logic             m_axis_tlast;

	int errors;
	int pending;

	// Sender state: remaining requests in the current burst, and whether
	// tvalid is currently held high by the sender.
	int burst_left;
	bit valid_up;
	int random_sent;

	// Receiver state. All of it starts at zero; tready is set at the first
	// edge, while reset is still asserted.
	int stall_mode;
	int mode_cycles;
	int pattern_pos;

	int idle_cycles;

	six_axis_top5_tracker_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	satt_rank_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Packs six axis values into tdata, accel_x in the lowest bits.
	function automatic logic [IN_W-1:0] pack_sample(int ax, int ay, int az,
		int rx, int ry, int rz);
		logic [IN_W-1:0] d;
		d = '0;
		d[0*SAMPLE_WIDTH +: SAMPLE_WIDTH] = ax[SAMPLE_WIDTH-1:0];
		d[1*SAMPLE_WIDTH +: SAMPLE_WIDTH] = ay[SAMPLE_WIDTH-1:0];
		d[2*SAMPLE_WIDTH +: SAMPLE_WIDTH] = az[SAMPLE_WIDTH-1:0];
		d[3*SAMPLE_WIDTH +: SAMPLE_WIDTH] = rx[SAMPLE_WIDTH-1:0];
		d[4*SAMPLE_WIDTH +: SAMPLE_WIDTH] = ry[SAMPLE_WIDTH-1:0];
		d[5*SAMPLE_WIDTH +: SAMPLE_WIDTH] = rz[SAMPLE_WIDTH-1:0];
		return d;
	endfunction

	// One axis value: mostly full-range random, with a share of extremes and
	// of small values so that ties show up often.
	function automatic int pick_axis_value();
		int v;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					default: v = -1;
				endcase
			end
			1, 2: v = int'($urandom_range(0, 8)) - 4;
			default: v = int'($signed(16'($urandom())));
		endcase
		return v;
	endfunction

	function automatic logic [IN_W-1:0] random_sample();
		return pack_sample(pick_axis_value(), pick_axis_value(), pick_axis_value(),
			pick_axis_value(), pick_axis_value(), pick_axis_value());
	endfunction

	// Waits until the checker has seen every owed result. The first edge lets
	// a closing sample taken in this step show up in the pending count.
	task automatic wait_results_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Presents one sample request and holds it until it is taken. tvalid is
	// only lowered when a burst ends or a pause is asked for, so back-to-back
	// requests never see it dropped and raised in the same step.
	task automatic send_sample(input logic [IN_W-1:0] d, input logic closes,
		input bit pause_after);
		int gap;
		s_axis_tdata  <= d;
		s_axis_tlast  <= closes;
		s_axis_tvalid <= 1'b1;
		valid_up = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0 || pause_after) begin
			s_axis_tvalid <= 1'b0;
			valid_up = 1'b0;
			if (pause_after)
				wait_results_drained();
			// The idle gap is never empty, so tvalid always drops before the next request.
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
			// Every so often a long burst gives a stretch with no idling.
			if ($urandom_range(0, 4) == 0)
				burst_left = $urandom_range(20, 60);
			else
				burst_left = $urandom_range(1, 8);
		end
	endtask

	// Receiver: changes its stall pattern every so often. Modes are: always
	// ready, mostly ready, mostly stalled, and a fixed ready/stall cycle.
	always @(posedge clk) begin
		if (mode_cycles == 0) begin
			stall_mode  <= $urandom_range(0, 3);
			mode_cycles <= $urandom_range(40, 200);
		end else begin
			mode_cycles <= mode_cycles - 1;
		end
		pattern_pos <= (pattern_pos == 7) ? 0 : pattern_pos + 1;
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= (pattern_pos < 3);
		endcase
	end

	// Watchdog: counts cycles in which neither channel takes a request.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
			(m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int win_len;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		burst_left    = 3;
		valid_up      = 1'b0;
		random_sent   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Windows of a single sample: one filled rank, four empty ones, with
		// both extremes on every axis.
		send_sample(pack_sample(32767, -32768, 0, -1, 1, 32767), 1'b1, 1'b0);
		send_sample(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768),
			1'b1, 1'b0);
		send_sample(pack_sample(32767, 32767, 32767, 32767, 32767, 32767),
			1'b1, 1'b0);

		// Equal values: every axis sees the same value four times.
		for (int i = 0; i < 4; i++)
			send_sample(pack_sample(7, -7, 0, 7, -7, 0), i == 3, 1'b0);

		// Seven samples: more than the five ranks, so the lowest fall off.
		// Axes rise, fall and alternate between the extremes.
		for (int i = 0; i < 7; i++)
			send_sample(pack_sample(i*5000 - 15000, 15000 - i*5000,
				(i % 2) ? 32767 : -32768, i*i, -i, 3 - i), i == 6, 1'b0);

		// Short window of three samples, then one that fills all five ranks.
		// The sender pauses after each until the results are back.
		for (int i = 0; i < 3; i++)
			send_sample(random_sample(), i == 2, i == 2);
		for (int i = 0; i < 5; i++)
			send_sample(random_sample(), i == 4, i == 4);

		// Random windows: mostly short, some single samples, and a few long
		// ones that keep accumulating far past the rank count.
		while (random_sent < RANDOM_SAMPLES) begin
			case ($urandom_range(0, 9))
				0: win_len = 1;
				1: win_len = $urandom_range(11, 40);
				default: win_len = $urandom_range(2, 10);
			endcase
			for (int i = 0; i < win_len; i++) begin
				send_sample(random_sample(), i == win_len - 1,
					(i == win_len - 1) && ($urandom_range(0, 7) == 0));
				random_sent++;
			end
		end

		if (valid_up)
			s_axis_tvalid <= 1'b0;
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[six_axis_top5_tracker_top.f]
src/satt_pkg.sv
src/satt_lane.sv
src/satt_merge.sv
src/six_axis_top5_tracker_top.sv
tb/sv/satt_rank_checker.sv
tb/sv/six_axis_top5_tracker_top_tb.sv
